### rtl/core/lifo_stack_with_indexed_access_defines.svh
// Assertion macros for the indexed-access LIFO stack
`ifndef LIFO_STACK_WITH_INDEXED_ACCESS_DEFINES_SVH
`define LIFO_STACK_WITH_INDEXED_ACCESS_DEFINES_SVH

// clocked assertion, off while reset is applied
`define LSIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion with the default failure message
`define LSIA_ASSERT_DEF(lbl, prop) \
  `LSIA_ASSERT(lbl, prop, "lsia: port property violated")

`endif

### rtl/core/lsia_pkg.sv
// Shared types and constants for the indexed-access LIFO stack
package lsia_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned MAX_DEPTH = 1024;
  localparam int unsigned PTR_W     = $clog2(MAX_DEPTH);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_DEPTH_RST = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_READ  = 3'd3,
    OP_WRITE = 3'd4
  } op_e;

  typedef struct packed {
    logic                    valid;
    logic                    wr_en;
    logic                    rd_en;
    logic [PTR_W-1:0]        addr;
    logic signed [VAL_W-1:0] wdata;
    logic signed [VAL_W-1:0] data;
    logic                    ok;
    logic [CNT_W-1:0]        count;
    logic                    full;
    logic                    empty;
  } txn_t;

endpackage

### rtl/core/lsia_ctrl.sv
// Head of the chain: fill count, depth register and transaction decode
module lsia_ctrl import lsia_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    in_valid_i,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output txn_t                    txn_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]    count_q, count_d;
  logic [CFG_W-1:0] depth_q, depth_d;
  logic [EW-1:0]    cfg_ext, dep_eff;
  logic             pos_ok;
  logic             nonempty;

  always_comb begin
    cfg_ext = EW'(depth_q);
    dep_eff = cfg_ext;
    if (cfg_ext == '0) begin
      dep_eff = EW'(1);
    end else if (cfg_ext > EW'(DEPTH)) begin
      dep_eff = EW'(DEPTH);
    end
  end

  assign depth_d  = cfg_we_i ? cfg_data_i : depth_q;
  assign pos_ok   = PW'(position_i) < PW'(count_q);
  assign nonempty = count_q != '0;

  always_comb begin
    txn_o       = '0;
    count_d     = count_q;
    txn_o.valid = in_valid_i;
    txn_o.wdata = value_i;
    unique case (op_e'(op_i))
      OP_PUSH: begin
        if (EW'(count_q) < dep_eff) begin
          txn_o.ok    = 1'b1;
          txn_o.wr_en = 1'b1;
          txn_o.addr  = PTR_W'(count_q);
          count_d     = count_q + CW'(1);
        end
      end
      OP_POP: begin
        if (nonempty) begin
          txn_o.ok    = 1'b1;
          txn_o.rd_en = 1'b1;
          txn_o.addr  = PTR_W'(count_q - CW'(1));
          count_d     = count_q - CW'(1);
        end
      end
      OP_PEEK: begin
        if (nonempty) begin
          txn_o.ok    = 1'b1;
          txn_o.rd_en = 1'b1;
          txn_o.addr  = PTR_W'(count_q - CW'(1));
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          txn_o.ok    = 1'b1;
          txn_o.rd_en = 1'b1;
          txn_o.addr  = PTR_W'(position_i);
        end
      end
      OP_WRITE: begin
        if (pos_ok) begin
          txn_o.ok    = 1'b1;
          txn_o.wr_en = 1'b1;
          txn_o.addr  = PTR_W'(position_i);
        end
      end
      default: begin
      end
    endcase
    txn_o.count = CNT_W'(count_d);
    txn_o.full  = EW'(count_d) >= dep_eff;
    txn_o.empty = count_d == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      depth_q <= CFG_DEPTH_RST;
    end else begin
      depth_q <= depth_d;
      if (adv_i && in_valid_i) begin
        count_q <= count_d;
      end
    end
  end

endmodule

### rtl/core/lsia_cell.sv
// One stack entry plus the transaction stage that passes over it
module lsia_cell import lsia_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  txn_t txn_i,
  output txn_t txn_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  txn_t                    txn_q, txn_d;
  logic                    hit;

  assign hit = txn_i.valid && (txn_i.addr == PTR_W'(IDX));

  always_comb begin
    txn_d   = txn_i;
    entry_d = entry_q;
    if (hit && txn_i.rd_en) begin
      txn_d.data = entry_q;
    end
    if (hit && txn_i.wr_en) begin
      entry_d = txn_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txn_q <= '0;
    end else if (adv_i) begin
      txn_q <= txn_d;
    end
  end

  assign txn_o = txn_q;

endmodule

### rtl/core/lifo_stack_with_indexed_access.sv
// Top level of the LIFO stack with indexed access, built as a chain of entry cells
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   op_i, value_i, position_i
//   out      output     out_valid_o/out_stall_i data_o, ok_o, count_o, full_res_o, empty_res_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (depth in use)
//
// One transaction per cycle is accepted while the chain is not stalled; its result is
// registered in every cell it travels through. Earlier transactions pass every cell first.
// A stall on a waiting result holds the whole chain and raises in_stall_o in the same cycle.
// Reset clears the fill count, sets the depth to 16 and empties the chain; entries
// hold no value until written. Configuration writes are taken in any cycle.
module lifo_stack_with_indexed_access import lsia_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic                    ok_o,
  output logic [CNT_W-1:0]        count_o,
  output logic                    full_res_o,
  output logic                    empty_res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  txn_t chain [DEPTH+1];
  logic adv;

  assign adv         = !chain[DEPTH].valid || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  lsia_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .value_i    (value_i),
    .position_i (position_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .txn_o      (chain[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lsia_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .txn_i  (chain[i]),
      .txn_o  (chain[i+1])
    );
  end

  assign out_valid_o = chain[DEPTH].valid;
  assign data_o      = chain[DEPTH].data;
  assign ok_o        = chain[DEPTH].ok;
  assign count_o     = chain[DEPTH].count;
  assign full_res_o  = chain[DEPTH].full;
  assign empty_res_o = chain[DEPTH].empty;

endmodule

### rtl/core/lsia_checker.sv
// Port-level assertions for the LIFO stack with indexed access
`include "lifo_stack_with_indexed_access_defines.svh"

module lsia_checker import lsia_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VAL_W-1:0] data_o,
  input logic                    ok_o,
  input logic                    full_res_o,
  input logic                    empty_res_o
);

  `LSIA_ASSERT(a_refused_zero, out_valid_o && !ok_o |-> data_o == '0, "refusal with data")
  `LSIA_ASSERT(a_full_empty, out_valid_o |-> !(full_res_o && empty_res_o), "full and empty")
  `LSIA_ASSERT_DEF(a_idle_ready, !out_valid_o |-> !in_stall_o)
  `LSIA_ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(data_o))

endmodule

bind lifo_stack_with_indexed_access lsia_checker u_lsia_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the indexed-access LIFO stack
module testbench;
  import lsia_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = STACK_DEPTH + 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned MAX_PRINTED = 40;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_ONES = -32'sd1;
  localparam logic signed [VAL_W-1:0] VAL_CHECKER = 32'sh5a5a_a5a5;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } stack_cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic                    ok;
    logic [CNT_W-1:0]        count;
    logic                    full;
    logic                    empty;
  } stack_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [OP_W-1:0]         op_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] data_o;
  logic                    ok_o;
  logic [CNT_W-1:0]        count_o;
  logic                    full_res_o;
  logic                    empty_res_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  logic signed [VAL_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned             stack_fill = 0;
  logic [CFG_W-1:0]        depth_cfg = CFG_DEPTH_RST;

  stack_cmd_t  op_queue[$];
  stack_res_t  stack_replies[$];
  stack_cmd_t  next_cmd;
  stack_res_t  head_reply;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  lifo_stack_with_indexed_access #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (data_o),
    .ok_o       (ok_o),
    .count_o    (count_o),
    .full_res_o (full_res_o),
    .empty_res_o(empty_res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic stack_res_t apply_stack_op(logic [OP_W-1:0] op,
                                                logic signed [VAL_W-1:0] val,
                                                logic [POS_W-1:0] pos);
    stack_res_t  r;
    int unsigned lim;
    lim = 32'(depth_cfg);
    if (lim < 1) lim = 1;
    if (lim > STACK_DEPTH) lim = STACK_DEPTH;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (stack_fill < lim) begin
          stack_mem[POS_W'(stack_fill)] = val;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.data = stack_mem[POS_W'(stack_fill)];
          r.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        if (stack_fill > 0) begin
          r.data = stack_mem[POS_W'(stack_fill - 1)];
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < stack_fill) begin
          r.data = stack_mem[pos];
          r.ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (pos < stack_fill) begin
          stack_mem[pos] = val;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(stack_fill);
    r.full = (stack_fill >= lim);
    r.empty = (stack_fill == 0);
    return r;
  endfunction

  function automatic stack_cmd_t random_cmd(bit grow);
    stack_cmd_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    c.value = $urandom();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: c.value = VAL_MAX;
        1: c.value = VAL_MIN;
        2: c.value = '0;
        default: c.value = VAL_ONES;
      endcase
    end
    c.pos = POS_W'($urandom_range(STACK_DEPTH - 1));
    if (roll < 4)
      c.op = OP_W'($urandom_range(2**OP_W - 1, OP_WRITE + 1));
    else if (grow)
      c.op = (roll < 50) ? OP_PUSH : (roll < 62) ? OP_POP : (roll < 74) ? OP_PEEK :
             (roll < 87) ? OP_READ : OP_WRITE;
    else
      c.op = (roll < 18) ? OP_PUSH : (roll < 58) ? OP_POP : (roll < 70) ? OP_PEEK :
             (roll < 85) ? OP_READ : OP_WRITE;
    return c;
  endfunction

  task automatic queue_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                          logic [POS_W-1:0] pos);
    stack_cmd_t c;
    c.op = op;
    c.value = val;
    c.pos = pos;
    op_queue.push_back(c);
  endtask

  task automatic report_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: mismatch on %s: want %h got %h", $time, field, want, got);
  endtask

  task automatic drain_stack();
    while (op_queue.size() != 0 || in_valid_i || stack_replies.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [CFG_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    depth_cfg = d;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        stack_replies.push_back(apply_stack_op(op_i, value_i, position_i));
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = op_queue.pop_front();
          in_valid_i <= 1'b1;
          op_i <= next_cmd.op;
          value_i <= next_cmd.value;
          position_i <= next_cmd.pos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (stack_replies.size() == 0) begin
          report_mismatch("unexpected transaction", '0, data_o);
        end else begin
          head_reply = stack_replies.pop_front();
          if (data_o !== head_reply.data) report_mismatch("data", head_reply.data, data_o);
          if (ok_o !== head_reply.ok)
            report_mismatch("ok", VAL_W'(head_reply.ok), VAL_W'(ok_o));
          if (count_o !== head_reply.count)
            report_mismatch("count", VAL_W'(head_reply.count), VAL_W'(count_o));
          if (full_res_o !== head_reply.full)
            report_mismatch("full_res", VAL_W'(head_reply.full), VAL_W'(full_res_o));
          if (empty_res_o !== head_reply.empty)
            report_mismatch("empty_res", VAL_W'(head_reply.empty), VAL_W'(empty_res_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int         depth_plan [12];
    bit         grow;
    int         run_left;
    stack_cmd_t c;
    depth_plan = '{0, 1, 2, 31, 5, 17, 3, 16, 8, 4, 12, 16};
    grow = 1'b1;
    run_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 8;
    recv_stall_pct = 56;
    queue_op(OP_PEEK, VAL_ONES, '0);
    queue_op(OP_POP, VAL_ONES, '0);
    queue_op(OP_READ, '0, '0);
    queue_op(OP_WRITE, VAL_MAX, POS_W'(STACK_DEPTH - 1));
    for (int k = OP_WRITE + 1; k < 2**OP_W; k++)
      queue_op(OP_W'(k), VAL_MAX, POS_W'(STACK_DEPTH - 1));
    queue_op(OP_PUSH, VAL_MAX, '0);
    queue_op(OP_PUSH, VAL_MIN, '0);
    queue_op(OP_PUSH, '0, '0);
    queue_op(OP_PUSH, VAL_ONES, '0);
    queue_op(OP_READ, '0, POS_W'(0));
    queue_op(OP_READ, '0, POS_W'(3));
    queue_op(OP_READ, '0, POS_W'(4));
    queue_op(OP_WRITE, VAL_CHECKER, POS_W'(1));
    queue_op(OP_READ, '0, POS_W'(1));
    queue_op(OP_WRITE, VAL_CHECKER, POS_W'(STACK_DEPTH - 1));
    queue_op(OP_PEEK, '0, '0);
    repeat (5) queue_op(OP_POP, '0, '0);
    queue_op(OP_PUSH, VAL_CHECKER, '0);
    queue_op(OP_READ, '0, POS_W'(STACK_DEPTH - 1));
    drain_stack();

    for (int p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 8 : (p < 8) ? 56 : 0;
      recv_stall_pct = (p < 4) ? 56 : (p < 8) ? 8 : 0;
      write_depth(CFG_W'(depth_plan[p]));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (run_left == 0) begin
          grow = ~grow;
          run_left = $urandom_range(40, 8);
        end
        run_left--;
        c = random_cmd(grow);
        op_queue.push_back(c);
      end
      repeat ($urandom_range(STACK_DEPTH)) queue_op(OP_PUSH, $urandom(), '0);
      drain_stack();
    end

    if (mismatches == 0 && stack_replies.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
